// ===== hw/rtl/rdq_pkg.sv =====
// Shared types and constants of the reversible deque unit.
package rdq_pkg;

  localparam int unsigned OpBits     = 3;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned FieldBits  = 32;

  localparam logic [OpBits-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OpBits-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OpBits-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OpBits-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OpBits-1:0] OP_REVERSE    = 3'd4;

  localparam logic [StatusBits-1:0] ST_DONE   = 2'd0;
  localparam logic [StatusBits-1:0] ST_POPPED = 2'd1;
  localparam logic [StatusBits-1:0] ST_EMPTY  = 2'd2;
  localparam logic [StatusBits-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic exec;
    logic finish_pop;
  } rdq_cmd_t;

  typedef struct packed {
    logic pop_ok;
    logic out_free;
  } rdq_sts_t;

endpackage

// ===== hw/rtl/rdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module rdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rdq_ctrl.sv =====
// Controller state machine of the reversible deque unit.
module rdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rdq_pkg::rdq_sts_t sts_i,
  output rdq_pkg::rdq_cmd_t cmd_o
);
  import rdq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && sts_i.pop_ok) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.exec       = accept;
  assign cmd_o.finish_pop = (state_q == S_READ);

endmodule

// ===== hw/rtl/rdq_datapath.sv =====
// Datapath of the reversible deque unit: ring pointers, count, direction flag and result register.
module rdq_datapath #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rdq_pkg::rdq_cmd_t                     cmd_i,
  output rdq_pkg::rdq_sts_t                     sts_o,
  input  logic [rdq_pkg::OpBits-1:0]            operation_i,
  input  logic signed [rdq_pkg::FieldBits-1:0]  push_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [rdq_pkg::FieldBits-1:0]  pop_value_o,
  output logic [rdq_pkg::StatusBits-1:0]        status_o
);
  import rdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  logic [AW-1:0] front_q, front_d, back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;

  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic          is_push, is_pop, full, empty, at_start;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata;
  logic signed [63:0]    push_ext, pop_ext;

  logic                         out_valid_q;
  logic signed [FieldBits-1:0]  out_value_q;
  logic [StatusBits-1:0]        out_status_q;

  assign is_push = (operation_i == OP_PUSH_BACK) || (operation_i == OP_PUSH_FRONT);
  assign is_pop  = (operation_i == OP_POP_BACK) || (operation_i == OP_POP_FRONT);
  assign full    = (count_q == FullCount);
  assign empty   = (count_q == '0);

  always_comb begin
    if (is_push) begin
      at_start = (operation_i == OP_PUSH_FRONT) ^ rev_q;
    end else begin
      at_start = (operation_i == OP_POP_FRONT) ^ rev_q;
    end
  end

  assign front_inc = (front_q == LastSlot) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LastSlot : front_q - 1'b1;
  assign back_inc  = (back_q == LastSlot) ? '0 : back_q + 1'b1;
  assign back_dec  = (back_q == '0) ? LastSlot : back_q - 1'b1;

  assign push_ext = 64'(push_value_i);
  assign wdata    = push_ext[VALUE_BITS-1:0];
  assign we       = cmd_i.exec && is_push && !full;
  assign waddr    = at_start ? front_dec : back_q;
  assign re       = cmd_i.exec && is_pop && !empty;
  assign raddr    = at_start ? front_q : back_dec;

  rdq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign pop_ext = 64'(signed'(rdata));

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    rev_d   = rev_q;
    if (we) begin
      if (at_start) begin
        front_d = front_dec;
      end else begin
        back_d = back_inc;
      end
      count_d = count_q + 1'b1;
    end
    if (re) begin
      if (at_start) begin
        front_d = front_inc;
      end else begin
        back_d = back_dec;
      end
      count_d = count_q - 1'b1;
    end
    if (cmd_i.exec && (operation_i == OP_REVERSE)) begin
      rev_d = !rev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      if ((cmd_i.exec && !re) || cmd_i.finish_pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_pop) begin
      out_value_q  <= pop_ext[FieldBits-1:0];
      out_status_q <= ST_POPPED;
    end else if (cmd_i.exec && !re) begin
      out_value_q <= '0;
      if (is_push && full) begin
        out_status_q <= ST_FULL;
      end else if (is_pop) begin
        out_status_q <= ST_EMPTY;
      end else begin
        out_status_q <= ST_DONE;
      end
    end
  end

  assign sts_o.pop_ok   = is_pop && !empty;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pop_value_o = out_value_q;
  assign status_o    = out_status_q;

endmodule

// ===== hw/rtl/reversible_deque_unit.sv =====
// Top level of the reversible deque unit.
//
// A bounded double-ended queue of signed values held in a ring of DEPTH RAM
// entries, with a reverse operation that only swaps which end is the front.
// The slave channel carries one operation per transaction: tuser holds the
// operation code (push back, push front, pop back, pop front, reverse) and
// tdata the value to push. The master channel returns exactly one result per
// operation: tdata holds the popped value (zero when none) and tuser the
// status (done, popped, empty or full).
// A push, a reverse, a pop on an empty queue or an unused code returns its
// result on the master side in the cycle after the input transaction. A
// successful pop passes through the registered read port of the entry RAM
// and then the result register before its result appears on the master side.
// A new operation is accepted while a result waits, provided the receiver
// takes that result in the same cycle; otherwise tready stays low until it
// does. Reset empties the queue and clears the direction at once; the RAM
// contents are not cleared, as no entry is read before it is written.
module reversible_deque_unit #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic signed [rdq_pkg::FieldBits-1:0] s_axis_tdata,  // push_value
  input  logic [rdq_pkg::OpBits-1:0]           s_axis_tuser,  // operation
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic signed [rdq_pkg::FieldBits-1:0] m_axis_tdata,  // pop_value
  output logic [rdq_pkg::StatusBits-1:0]       m_axis_tuser   // status
);
  import rdq_pkg::*;

  rdq_cmd_t cmd;
  rdq_sts_t sts;

  rdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rdq_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (s_axis_tuser),
    .push_value_i (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pop_value_o  (m_axis_tdata),
    .status_o     (m_axis_tuser)
  );

endmodule
